// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk with reset held off through rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

    // grid defaults
    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 128;

    // field widths
    localparam int X_W     = 6;
    localparam int Y_W     = 7;
    localparam int LEN_W   = 13;
    localparam int TRIES_W = 5;

    localparam logic [TRIES_W-1:0] TRIES_RESET = 5'd30;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DIR   = 1'b1;

    // direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic           kind;
        logic [X_W-1:0] start_x;
        logic [Y_W-1:0] start_y;
        logic [1:0]     rand_dir;
    } dmc_in_t;

    typedef struct packed {
        logic             carved;
        logic [X_W-1:0]   from_x;
        logic [Y_W-1:0]   from_y;
        logic [1:0]       carve_dir;
        logic [X_W-1:0]   to_x;
        logic [Y_W-1:0]   to_y;
        logic             done_res;
        logic [X_W-1:0]   far_x;
        logic [Y_W-1:0]   far_y;
        logic [LEN_W-1:0] far_len;
    } dmc_out_t;

    // memory write strobes from the controller
    typedef struct packed {
        logic vis_we;
        logic vis_wbit;
        logic stk_we;
    } dmc_mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_EVAL,
        ST_CHECK,
        ST_LOAD,
        ST_FINISH
    } dmc_state_t;

    // fit a zero-extended value to the result field widths
    function automatic logic [X_W-1:0] fit_x(logic [31:0] v);
        return v[X_W-1:0];
    endfunction

    function automatic logic [Y_W-1:0] fit_y(logic [31:0] v);
        return v[Y_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] fit_len(logic [31:0] v);
        return v[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dmc_ram.sv =====
`default_nettype none

module dmc_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dmc_ctrl.sv =====
`default_nettype none

module dmc_ctrl #(
    parameter  int GRID_W = dmc_pkg::GRID_W_DEF,
    parameter  int GRID_H = dmc_pkg::GRID_H_DEF,
    localparam int XW     = $clog2(GRID_W),
    localparam int YW     = $clog2(GRID_H),
    localparam int CELLS  = GRID_W * GRID_H,
    localparam int AW     = $clog2(CELLS),
    localparam int TW     = dmc_pkg::TRIES_W,
    localparam int SW     = XW + YW + TW
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [TW-1:0]         cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dmc_pkg::dmc_in_t      in_item,
    input  wire logic                  slot_free,
    output logic                       res_load,
    output dmc_pkg::dmc_out_t          res_item,
    output dmc_pkg::dmc_mem_ctl_t      mem_ctl,
    output logic [AW-1:0]              vis_waddr,
    output logic [AW-1:0]              vis_raddr,
    input  wire logic                  vis_rdata,
    output logic [AW-1:0]              stk_waddr,
    output logic [AW-1:0]              stk_raddr,
    output logic [SW-1:0]              stk_wdata,
    input  wire logic [SW-1:0]         stk_rdata
);

    localparam int DW = AW + 1;

    dmc_pkg::dmc_state_t state_reg, state_next;

    logic [DW-1:0]               depth_reg, depth_next;
    logic [TW-1:0]               tpc_reg;
    logic [XW-1:0]               top_x_reg, top_x_next;
    logic [YW-1:0]               top_y_reg, top_y_next;
    logic [TW-1:0]               top_t_reg, top_t_next;
    logic [XW-1:0]               nb_x_reg, nb_x_next;
    logic [YW-1:0]               nb_y_reg, nb_y_next;
    logic                        nb_in_reg, nb_in_next;
    logic [1:0]                  dir_reg, dir_next;
    logic [XW-1:0]               start_x_reg, start_x_next;
    logic [YW-1:0]               start_y_reg, start_y_next;
    logic                        start_in_reg, start_in_next;
    logic [AW-1:0]               vis_addr_reg, vis_addr_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [dmc_pkg::X_W-1:0]     far_x_reg, far_x_next;
    logic [dmc_pkg::Y_W-1:0]     far_y_reg, far_y_next;
    logic [AW-1:0]               far_len_reg, far_len_next;
    dmc_pkg::dmc_out_t           res_reg, res_next;

    // neighbour of the top cell for the offered direction
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic          nb_in;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] start_addr;
    logic          start_in;
    logic          carve_ok;
    logic          pop_now;
    logic          clr_last;

    always_comb
    begin
        nb_x  = top_x_reg;
        nb_y  = top_y_reg;
        nb_in = 1'b1;
        unique case (in_item.rand_dir)
            dmc_pkg::DIR_UP:
            begin
                if (top_y_reg == '0)
                    nb_in = 1'b0;
                else
                    nb_y = top_y_reg - YW'(1);
            end
            dmc_pkg::DIR_DOWN:
            begin
                if (32'(top_y_reg) + 32'd1 >= 32'(GRID_H))
                    nb_in = 1'b0;
                else
                    nb_y = top_y_reg + YW'(1);
            end
            dmc_pkg::DIR_RIGHT:
            begin
                if (32'(top_x_reg) + 32'd1 >= 32'(GRID_W))
                    nb_in = 1'b0;
                else
                    nb_x = top_x_reg + XW'(1);
            end
            dmc_pkg::DIR_LEFT:
            begin
                if (top_x_reg == '0)
                    nb_in = 1'b0;
                else
                    nb_x = top_x_reg - XW'(1);
            end
        endcase
    end

    assign nb_addr    = AW'(nb_y) * AW'(GRID_W) + AW'(nb_x);
    assign start_addr = AW'(in_item.start_y) * AW'(GRID_W) + AW'(in_item.start_x);
    assign start_in   = (32'(in_item.start_x) < 32'(GRID_W)) &&
                        (32'(in_item.start_y) < 32'(GRID_H));

    // decisions used by the next-state and output logic
    assign carve_ok = nb_in_reg && !vis_rdata && (depth_reg < DW'(CELLS));
    assign pop_now  = (depth_reg != '0) && (top_t_reg >= tpc_reg);
    assign clr_last = (clr_cnt_reg == AW'(CELLS - 1));

    // fixed memory addressing
    assign vis_raddr = nb_addr;
    assign stk_waddr = AW'(depth_reg - DW'(1));
    assign stk_raddr = AW'(depth_reg - DW'(2));
    assign stk_wdata = {top_x_reg, top_y_reg, top_t_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.kind == dmc_pkg::KIND_START)
                        state_next = dmc_pkg::ST_CLEAR;
                    else if (depth_reg != '0)
                        state_next = dmc_pkg::ST_EVAL;
                    else
                        state_next = dmc_pkg::ST_FINISH;
                end
            end
            dmc_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = start_in_reg ? dmc_pkg::ST_MARK : dmc_pkg::ST_FINISH;
            end
            dmc_pkg::ST_MARK:  state_next = dmc_pkg::ST_CHECK;
            dmc_pkg::ST_EVAL:  state_next = dmc_pkg::ST_CHECK;
            dmc_pkg::ST_CHECK:
            begin
                if (pop_now && (depth_reg > DW'(1)))
                    state_next = dmc_pkg::ST_LOAD;
                else
                    state_next = dmc_pkg::ST_FINISH;
            end
            dmc_pkg::ST_LOAD:  state_next = dmc_pkg::ST_CHECK;
            dmc_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = dmc_pkg::ST_IDLE;
            end
            default:           state_next = dmc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        depth_next    = depth_reg;
        top_x_next    = top_x_reg;
        top_y_next    = top_y_reg;
        top_t_next    = top_t_reg;
        nb_x_next     = nb_x_reg;
        nb_y_next     = nb_y_reg;
        nb_in_next    = nb_in_reg;
        dir_next      = dir_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        start_in_next = start_in_reg;
        vis_addr_next = vis_addr_reg;
        clr_cnt_next  = clr_cnt_reg;
        far_x_next    = far_x_reg;
        far_y_next    = far_y_reg;
        far_len_next  = far_len_reg;
        res_next      = res_reg;
        mem_ctl       = '0;
        vis_waddr     = vis_addr_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;

        unique case (state_reg)
            dmc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next = '0;
                    if (in_item.kind == dmc_pkg::KIND_START)
                    begin
                        depth_next    = '0;
                        far_x_next    = in_item.start_x;
                        far_y_next    = in_item.start_y;
                        far_len_next  = '0;
                        start_x_next  = XW'(in_item.start_x);
                        start_y_next  = YW'(in_item.start_y);
                        start_in_next = start_in;
                        vis_addr_next = start_addr;
                        clr_cnt_next  = '0;
                    end
                    else if (depth_reg != '0)
                    begin
                        // spend one try of the top frame
                        top_t_next    = top_t_reg + TW'(1);
                        nb_x_next     = nb_x;
                        nb_y_next     = nb_y;
                        nb_in_next    = nb_in;
                        dir_next      = in_item.rand_dir;
                        vis_addr_next = nb_addr;
                    end
                end
            end
            dmc_pkg::ST_CLEAR:
            begin
                // sweep the visited map, one cell a cycle
                mem_ctl.vis_we   = 1'b1;
                mem_ctl.vis_wbit = 1'b0;
                vis_waddr        = clr_cnt_reg;
                clr_cnt_next     = clr_cnt_reg + AW'(1);
            end
            dmc_pkg::ST_MARK:
            begin
                mem_ctl.vis_we   = 1'b1;
                mem_ctl.vis_wbit = 1'b1;
                top_x_next       = start_x_reg;
                top_y_next       = start_y_reg;
                top_t_next       = '0;
                depth_next       = DW'(1);
            end
            dmc_pkg::ST_EVAL:
            begin
                if (carve_ok)
                begin
                    // mark neighbour, spill old top, neighbour becomes top
                    mem_ctl.vis_we     = 1'b1;
                    mem_ctl.vis_wbit   = 1'b1;
                    mem_ctl.stk_we     = 1'b1;
                    top_x_next         = nb_x_reg;
                    top_y_next         = nb_y_reg;
                    top_t_next         = '0;
                    depth_next         = depth_reg + DW'(1);
                    res_next.carved    = 1'b1;
                    res_next.from_x    = dmc_pkg::fit_x(32'(top_x_reg));
                    res_next.from_y    = dmc_pkg::fit_y(32'(top_y_reg));
                    res_next.carve_dir = dir_reg;
                    res_next.to_x      = dmc_pkg::fit_x(32'(nb_x_reg));
                    res_next.to_y      = dmc_pkg::fit_y(32'(nb_y_reg));
                    if (AW'(depth_reg) > far_len_reg)
                    begin
                        far_x_next   = dmc_pkg::fit_x(32'(nb_x_reg));
                        far_y_next   = dmc_pkg::fit_y(32'(nb_y_reg));
                        far_len_next = AW'(depth_reg);
                    end
                end
            end
            dmc_pkg::ST_CHECK:
            begin
                // backtrack out of a spent frame
                if (pop_now)
                    depth_next = depth_reg - DW'(1);
            end
            dmc_pkg::ST_LOAD:
            begin
                {top_x_next, top_y_next, top_t_next} = stk_rdata;
            end
            dmc_pkg::ST_FINISH:
            begin
                res_load = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    // result item: carve fields plus current status
    always_comb
    begin
        res_item          = res_reg;
        res_item.done_res = (depth_reg == '0);
        res_item.far_x    = far_x_reg;
        res_item.far_y    = far_y_reg;
        res_item.far_len  = dmc_pkg::fit_len(32'(far_len_reg));
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dmc_pkg::ST_IDLE;
            depth_reg   <= '0;
            tpc_reg     <= dmc_pkg::TRIES_RESET;
            far_x_reg   <= '0;
            far_y_reg   <= '0;
            far_len_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            far_x_reg   <= far_x_next;
            far_y_reg   <= far_y_next;
            far_len_reg <= far_len_next;
            if (cfg_we)
                tpc_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_x_reg    <= top_x_next;
        top_y_reg    <= top_y_next;
        top_t_reg    <= top_t_next;
        nb_x_reg     <= nb_x_next;
        nb_y_reg     <= nb_y_next;
        nb_in_reg    <= nb_in_next;
        dir_reg      <= dir_next;
        start_x_reg  <= start_x_next;
        start_y_reg  <= start_y_next;
        start_in_reg <= start_in_next;
        vis_addr_reg <= vis_addr_next;
        clr_cnt_reg  <= clr_cnt_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_maze_carver.sv =====
// Randomized depth-first maze carver on a GRID_W x GRID_H grid.
// Input channel in_valid/in_ready/in_item: a start item (kind 0) clears the
// visited map and pushes the start cell if on the grid; a direction (kind 1)
// item spends one try of the top cell and may carve an unvisited neighbour.
// Output channel out_valid/out_ready/out_item: exactly one result item per
// input item, carrying the carved wall pair, the done flag and the deepest
// cell reached so far.
// A direction item passes EVAL and CHECK, then a stack read in LOAD and
// CHECK again per popped frame that leaves one below, then FINISH; into
// an empty stack it goes straight to FINISH. A start item sweeps the visited
// map one cell per cycle, then passes MARK, CHECK and FINISH, or goes from
// the sweep straight to FINISH if off the grid. Items are processed one at
// a time; a new item is accepted the cycle after the previous result is
// loaded. A stalled receiver holds the result in the output register; the
// next item is still accepted and held until the register drains.
// cfg_we/cfg_data write tries_per_cell (reset value 30); the user must write
// it only while idle, which the block does not enforce. Reset clears the
// stack and deepest cell; each start item's sweep clears the visited map.
`default_nettype none

module dfs_maze_carver #(
    parameter int GRID_W = dmc_pkg::GRID_W_DEF,
    parameter int GRID_H = dmc_pkg::GRID_H_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dmc_pkg::TRIES_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire dmc_pkg::dmc_in_t              in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dmc_pkg::dmc_out_t                  out_item
);

    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = XW + YW + dmc_pkg::TRIES_W;

    dmc_pkg::dmc_mem_ctl_t mem_ctl;
    dmc_pkg::dmc_out_t     res_item;
    logic                  res_load;
    logic                  slot_free;
    logic [AW-1:0]         vis_waddr, vis_raddr;
    logic                  vis_rdata;
    logic [AW-1:0]         stk_waddr, stk_raddr;
    logic [SW-1:0]         stk_wdata, stk_rdata;

    logic                  out_valid_reg, out_valid_next;
    dmc_pkg::dmc_out_t     out_item_reg;

    dmc_ctrl #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res_item  (res_item),
        .mem_ctl   (mem_ctl),
        .vis_waddr (vis_waddr),
        .vis_raddr (vis_raddr),
        .vis_rdata (vis_rdata),
        .stk_waddr (stk_waddr),
        .stk_raddr (stk_raddr),
        .stk_wdata (stk_wdata),
        .stk_rdata (stk_rdata)
    );

    // visited map, one bit per cell
    dmc_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_vis_ram (
        .clk   (clk),
        .we    (mem_ctl.vis_we),
        .waddr (vis_waddr),
        .wdata (mem_ctl.vis_wbit),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    // frames below the top: column, row, tries used
    dmc_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (mem_ctl.stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // output register
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_item_reg <= res_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dmc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dmc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire dmc_pkg::dmc_out_t           out_item
);

    logic adj_ok;
    logic blank_ok;

    // a carved pair is two cells next to each other in the carve direction
    assign adj_ok =
        ((out_item.carve_dir == dmc_pkg::DIR_UP) && (out_item.to_x == out_item.from_x) &&
         (out_item.to_y == out_item.from_y - 7'd1)) ||
        ((out_item.carve_dir == dmc_pkg::DIR_DOWN) && (out_item.to_x == out_item.from_x) &&
         (out_item.to_y == out_item.from_y + 7'd1)) ||
        ((out_item.carve_dir == dmc_pkg::DIR_RIGHT) && (out_item.to_y == out_item.from_y) &&
         (out_item.to_x == out_item.from_x + 6'd1)) ||
        ((out_item.carve_dir == dmc_pkg::DIR_LEFT) && (out_item.to_y == out_item.from_y) &&
         (out_item.to_x == out_item.from_x - 6'd1));

    // no carve means the wall fields are all zero
    assign blank_ok = (out_item.from_x == '0) && (out_item.from_y == '0) &&
                      (out_item.carve_dir == '0) && (out_item.to_x == '0) &&
                      (out_item.to_y == '0);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")
    `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "result item changed")
    `ASSERT_SAME(a_carve_adjacent, out_valid && out_item.carved, adj_ok, "carved pair not adjacent")
    `ASSERT_SAME(a_blank_fields, out_valid && !out_item.carved, blank_ok, "wall fields not zero")
    `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item accepted")

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (.*);

`default_nettype wire

// ===== tb/dfs_maze_carver_carve_check.sv =====
`timescale 1ns / 1ps

// Watches both channels and the tries register, predicts each result of the
// maze carver and compares it with what comes out.
module dfs_maze_carver_carve_check (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [dmc_pkg::TRIES_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire dmc_pkg::dmc_in_t            in_item,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire dmc_pkg::dmc_out_t           out_item,
    output int                               fail_count,
    output int                               outstanding,
    output logic                             maze_open
);

    localparam int GRID_W = dmc_pkg::GRID_W_DEF;
    localparam int GRID_H = dmc_pkg::GRID_H_DEF;
    localparam int CELLS  = GRID_W * GRID_H;
    localparam int XB     = dmc_pkg::X_W;
    localparam int YB     = dmc_pkg::Y_W;
    localparam int LB     = dmc_pkg::LEN_W;

    // predicted carver state
    bit                          visited [CELLS];
    logic [XB-1:0]               frame_x [CELLS];
    logic [YB-1:0]               frame_y [CELLS];
    logic [7:0]                  frame_tries [CELLS];
    int                          stack_depth;
    int                          far_x;
    int                          far_y;
    int                          far_len;
    logic [dmc_pkg::TRIES_W-1:0] tries_limit;

    dmc_pkg::dmc_out_t expected_q [$];
    int                mismatches;

    // mark a cell visited and put it on top of the stack
    task automatic push_frame(input int x, input int y);
        if (stack_depth < CELLS)
        begin
            visited[y * GRID_W + x] = 1'b1;
            frame_x[stack_depth] = XB'(x);
            frame_y[stack_depth] = YB'(y);
            frame_tries[stack_depth] = '0;
            stack_depth++;
        end
    endtask

    // backtrack over every frame whose tries are used up
    task automatic drop_spent();
        while (stack_depth > 0 && frame_tries[stack_depth - 1] >= tries_limit)
            stack_depth--;
    endtask

    // one item through the carver: updates the state, returns the result
    task automatic carve_step(input dmc_pkg::dmc_in_t it, output dmc_pkg::dmc_out_t res);
        int cx;
        int cy;
        int nx;
        int ny;
        int i;
        bit in_grid;
        res = '0;
        if (it.kind == dmc_pkg::KIND_START)
        begin
            for (i = 0; i < CELLS; i++)
                visited[i] = 1'b0;
            stack_depth = 0;
            far_x = int'(it.start_x);
            far_y = int'(it.start_y);
            far_len = 0;
            if (it.start_x < GRID_W && it.start_y < GRID_H)
                push_frame(int'(it.start_x), int'(it.start_y));
            drop_spent();
        end
        else if (stack_depth > 0)
        begin
            cx = int'(frame_x[stack_depth - 1]);
            cy = int'(frame_y[stack_depth - 1]);
            nx = cx;
            ny = cy;
            in_grid = 1'b1;
            // tries counter saturates
            if (frame_tries[stack_depth - 1] != 8'hFF)
                frame_tries[stack_depth - 1] = frame_tries[stack_depth - 1] + 8'd1;
            case (it.rand_dir)
                dmc_pkg::DIR_UP:
                begin
                    if (cy == 0)
                        in_grid = 1'b0;
                    else
                        ny = cy - 1;
                end
                dmc_pkg::DIR_DOWN:
                    ny = cy + 1;
                dmc_pkg::DIR_RIGHT:
                    nx = cx + 1;
                default:
                begin
                    if (cx == 0)
                        in_grid = 1'b0;
                    else
                        nx = cx - 1;
                end
            endcase
            if (nx >= GRID_W || ny >= GRID_H)
                in_grid = 1'b0;
            if (in_grid && !visited[ny * GRID_W + nx] && stack_depth < CELLS)
            begin
                res.carved    = 1'b1;
                res.from_x    = XB'(cx);
                res.from_y    = YB'(cy);
                res.carve_dir = it.rand_dir;
                res.to_x      = XB'(nx);
                res.to_y      = YB'(ny);
                // path length to the new cell is the depth before the push
                if (stack_depth > far_len)
                begin
                    far_x = nx;
                    far_y = ny;
                    far_len = stack_depth;
                end
                push_frame(nx, ny);
            end
            drop_spent();
        end
        res.done_res = (stack_depth == 0);
        res.far_x    = XB'(far_x);
        res.far_y    = YB'(far_y);
        res.far_len  = LB'(far_len);
    endtask

    function automatic int field_miss(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // sample both channels at each edge; results are checked before the
    // new item is predicted since no result can belong to an item of this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        dmc_pkg::dmc_out_t want;
        dmc_pkg::dmc_out_t res;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < CELLS; i++)
                visited[i] = 1'b0;
            stack_depth = 0;
            far_x = 0;
            far_y = 0;
            far_len = 0;
            tries_limit = dmc_pkg::TRIES_RESET;
            expected_q.delete();
            mismatches = 0;
            outstanding <= 0;
            maze_open <= 1'b0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
                tries_limit = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no input item pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    mismatches += field_miss("carved", want.carved, out_item.carved)
                        + field_miss("from_x", want.from_x, out_item.from_x)
                        + field_miss("from_y", want.from_y, out_item.from_y)
                        + field_miss("carve_dir", want.carve_dir, out_item.carve_dir)
                        + field_miss("to_x", want.to_x, out_item.to_x)
                        + field_miss("to_y", want.to_y, out_item.to_y)
                        + field_miss("done_res", want.done_res, out_item.done_res)
                        + field_miss("far_x", want.far_x, out_item.far_x)
                        + field_miss("far_y", want.far_y, out_item.far_y)
                        + field_miss("far_len", want.far_len, out_item.far_len);
                end
            end
            if (in_valid && in_ready)
            begin
                carve_step(in_item, res);
                expected_q.push_back(res);
            end
            outstanding <= expected_q.size();
            maze_open <= (stack_depth != 0);
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/dfs_maze_carver_tb.sv =====
`timescale 1ns / 1ps

module dfs_maze_carver_tb;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int PHASE_ITEMS  = 200;
    localparam int XB           = dmc_pkg::X_W;
    localparam int YB           = dmc_pkg::Y_W;
    localparam int TB           = dmc_pkg::TRIES_W;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [TB-1:0]     cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    dmc_pkg::dmc_in_t  in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    dmc_pkg::dmc_out_t out_item;

    int   fail_count;
    int   outstanding;
    logic maze_open;

    // idle odds in percent per cycle
    int send_idle = 0;
    int recv_idle = 0;
    // items of the current phase that the carver acts on
    int live_items;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    dfs_maze_carver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    dfs_maze_carver_carve_check carve_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .maze_open   (maze_open)
    );

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    function automatic dmc_pkg::dmc_in_t make_item(logic kind, int x, int y, logic [1:0] dir);
        dmc_pkg::dmc_in_t it;
        it.kind     = kind;
        it.start_x  = XB'(x);
        it.start_y  = YB'(y);
        it.rand_dir = dir;
        return it;
    endfunction

    function automatic dmc_pkg::dmc_in_t rand_item(logic kind);
        return make_item(kind, $urandom_range(2 ** XB - 1), $urandom_range(2 ** YB - 1),
                         2'($urandom_range(3)));
    endfunction

    // present one item, with random sender gaps ahead of it
    task automatic send_item(input dmc_pkg::dmc_in_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_tries(input logic [TB-1:0] value);
        drain();
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one maze: a start, then random directions until the stack empties or
    // the budget runs out; now and then a stray start restarts it.
    // maze_open lags one item behind, so a direction sent into an empty
    // stack is noticed one item later and taken back off the count.
    task automatic run_maze(input int budget);
        int dirs;
        bit last_start;
        send_item(rand_item(dmc_pkg::KIND_START));
        live_items++;
        last_start = 1'b1;
        dirs = 0;
        while (dirs < budget)
        begin
            if (!last_start && !maze_open)
            begin
                live_items--;
                break;
            end
            if ($urandom_range(99) < 2)
            begin
                send_item(rand_item(dmc_pkg::KIND_START));
                last_start = 1'b1;
            end
            else
            begin
                send_item(rand_item(dmc_pkg::KIND_DIR));
                last_start = 1'b0;
                dirs++;
            end
            live_items++;
        end
    endtask

    task automatic run_phase(input int sender_gap, input int receiver_gap);
        int r;
        logic [TB-1:0] limit;
        send_idle = sender_gap;
        recv_idle <= receiver_gap;
        live_items = 0;
        while (live_items < PHASE_ITEMS)
        begin
            // mostly large limits; the short-lived settings less often
            r = $urandom_range(99);
            if (r < 5)
                limit = TB'(0);
            else if (r < 15)
                limit = TB'(1);
            else if (r < 25)
                limit = TB'(31);
            else if (r < 35)
                limit = TB'(2);
            else
                limit = TB'($urandom_range(31, 3));
            write_tries(limit);
            run_maze($urandom_range(90, 15));
        end
    endtask

    initial
    begin : stimulus
        send_idle = 22;
        recv_idle <= 79;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // direction before any maze exists: ignored
        send_item(make_item(dmc_pkg::KIND_DIR, 63, 127, dmc_pkg::DIR_LEFT));
        // top-left corner: both outer edges, a carve, a visited neighbor
        send_item(make_item(dmc_pkg::KIND_START, 0, 0, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_LEFT));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_DOWN));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_RIGHT));
        // bottom-right corner
        send_item(make_item(dmc_pkg::KIND_START, 63, 127, dmc_pkg::DIR_LEFT));
        send_item(make_item(dmc_pkg::KIND_DIR, 63, 127, dmc_pkg::DIR_DOWN));
        send_item(make_item(dmc_pkg::KIND_DIR, 63, 127, dmc_pkg::DIR_RIGHT));
        send_item(make_item(dmc_pkg::KIND_DIR, 63, 127, dmc_pkg::DIR_LEFT));
        send_item(make_item(dmc_pkg::KIND_DIR, 63, 127, dmc_pkg::DIR_UP));
        // zero tries: start cell popped at once, next direction ignored
        write_tries(TB'(0));
        send_item(make_item(dmc_pkg::KIND_START, 10, 20, dmc_pkg::DIR_DOWN));
        send_item(make_item(dmc_pkg::KIND_DIR, 10, 20, dmc_pkg::DIR_RIGHT));
        // one try per cell: a dead end unwinds the whole stack in one item
        write_tries(TB'(1));
        send_item(make_item(dmc_pkg::KIND_START, 5, 5, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_UP));
        send_item(make_item(dmc_pkg::KIND_DIR, 0, 0, dmc_pkg::DIR_DOWN));
        // largest limit
        write_tries(TB'(31));
        send_item(make_item(dmc_pkg::KIND_START, 32, 64, dmc_pkg::DIR_RIGHT));
        send_item(make_item(dmc_pkg::KIND_DIR, 32, 64, dmc_pkg::DIR_RIGHT));
        send_item(make_item(dmc_pkg::KIND_DIR, 32, 64, dmc_pkg::DIR_LEFT));
        send_item(make_item(dmc_pkg::KIND_DIR, 32, 64, dmc_pkg::DIR_DOWN));
        send_item(make_item(dmc_pkg::KIND_DIR, 32, 64, dmc_pkg::DIR_DOWN));

        run_phase(22, 79);
        run_phase(79, 22);
        run_phase(0, 0);

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
